// File: sv/wnts_pkg.sv
// Shared types, constants and name helpers for the wildcard name table search block.
package wnts_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int NAME_CHARS  = 8;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int NAME_W      = 64;

    localparam logic [7:0]        WILD_CHAR = 8'h3F;
    localparam logic [NAME_W-1:0] NULL_WORD = 64'h0000_0000_4C4C_554E;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_WILD   = 2'd1,
        CMD_EXACT  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_MATCH    = 3'd0,
        ST_NO_MATCH = 3'd1,
        ST_APPENDED = 3'd2,
        ST_FULL     = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    // Upper-case one byte; only 'a' to 'z' change.
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // Upper-case every byte of a word.
    function automatic logic [NAME_W-1:0] fold_word(input logic [NAME_W-1:0] w);
        logic [NAME_W-1:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = fold_char(w[8*i +: 8]);
        end
        return r;
    endfunction

    // Keep the characters up to the first zero byte and zero the rest.
    function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] w);
        logic [NAME_W-1:0] r;
        logic              ended;
        r     = '0;
        ended = 1'b0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            if (w[8*i +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (!ended) begin
                r[8*i +: 8] = w[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

// File: sv/wnts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wnts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/wnts_match.sv
// Name compare unit: wildcard or exact case-insensitive match of query against one entry.
module wnts_match (
    input  wnts_pkg::t_cmd                   i_mode,
    input  logic [wnts_pkg::NAME_W-1:0]      i_query,
    input  logic [wnts_pkg::NAME_W-1:0]      i_entry,
    output logic                             o_hit
);

    logic wild_hit;
    logic exact_hit;

    // Walk positions while both names run on and agree; judge the stop position
    always_comb begin
        logic [7:0] ca;
        logic [7:0] cb;
        logic       stopped;
        logic       agree;
        wild_hit = 1'b1;
        stopped  = 1'b0;
        for (int i = 0; i < wnts_pkg::NAME_CHARS; i++) begin
            ca    = i_query[8*i +: 8];
            cb    = i_entry[8*i +: 8];
            agree = (ca != 8'h00) && (cb != 8'h00) &&
                    ((wnts_pkg::fold_char(ca) == wnts_pkg::fold_char(cb)) ||
                     (ca == wnts_pkg::WILD_CHAR) || (cb == wnts_pkg::WILD_CHAR));
            if (!stopped && !agree) begin
                stopped  = 1'b1;
                wild_hit = (ca == wnts_pkg::WILD_CHAR) || (cb == wnts_pkg::WILD_CHAR) ||
                           (ca == cb);
            end
        end
    end

    assign exact_hit = (wnts_pkg::fold_word(i_query) == wnts_pkg::fold_word(i_entry));
    assign o_hit     = (i_mode == wnts_pkg::CMD_WILD) ? wild_hit : exact_hit;

endmodule

// File: sv/wildcard_name_table_search_top.sv
// Top level: name table, scan sequencer and result word register.
//
// Input channel (i_valid / o_ready) carries a command and an eight-byte name.
// Output channel (o_valid / i_ready) carries result words: status, entry index
// and a last flag set on the final word that a command produces.
// One command is processed at a time; o_ready is high only when the sequencer
// is idle. Append and clear go to the emit state, which loads their word into
// the output register once that register is free.
// A search reads the table through one RAM read port and one shared compare
// unit, one entry per cycle unless a stalled receiver holds the scan: wildcard
// search scans newest entry down to disabled_count and emits every hit; exact
// lookup scans upward and stops at the first hit. Wildcard hits are held one
// deep so the final hit can carry the last flag; a stalled receiver freezes
// the scan in place when a newer hit must release the held one, so nothing is
// dropped. disabled_count is written through i_cfg_wr_en / i_cfg_wr_data; the
// user must write it only while idle, as the block itself does not enforce it.
// Synchronous active-low reset empties the table (entry count to zero),
// clears disabled_count and the output valid flag; no clearing pass is needed.
module wildcard_name_table_search_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic [wnts_pkg::NAME_W-1:0]   i_name_chars,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_status,
    output logic [wnts_pkg::IDX_W-1:0]    o_entry_index,
    output logic                          o_last,
    input  logic                          i_cfg_wr_en,
    input  logic [wnts_pkg::CNT_W-1:0]    i_cfg_wr_data
);

    wnts_pkg::t_state               r_state, n_state;
    wnts_pkg::t_cmd                 r_cmd, n_cmd;
    logic [wnts_pkg::NAME_W-1:0]    r_q, n_q;
    logic [wnts_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [wnts_pkg::CNT_W-1:0]     r_dis;
    logic [wnts_pkg::CNT_W-1:0]     r_cur, n_cur;
    logic                           r_pend_valid, n_pend_valid;
    logic [wnts_pkg::IDX_W-1:0]     r_pend_idx, n_pend_idx;
    wnts_pkg::t_status              r_fin_status, n_fin_status;
    logic [wnts_pkg::IDX_W-1:0]     r_fin_idx, n_fin_idx;
    logic                           r_out_valid, n_out_valid;
    wnts_pkg::t_status              r_out_status, n_out_status;
    logic [wnts_pkg::IDX_W-1:0]     r_out_idx, n_out_idx;
    logic                           r_out_last, n_out_last;

    logic                           accept;
    logic                           out_free;
    logic [wnts_pkg::NAME_W-1:0]    in_name;
    logic                           in_empty;
    logic                           wr_en;
    logic                           rd_en;
    logic [wnts_pkg::NAME_W-1:0]    rd_data;
    logic                           hit;
    logic                           last_entry;

    assign o_ready  = (r_state == wnts_pkg::S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign in_name  = wnts_pkg::normalize(i_name_chars);
    assign in_empty = (in_name == '0) || (wnts_pkg::fold_word(in_name) == wnts_pkg::NULL_WORD);
    assign wr_en    = accept && (wnts_pkg::t_cmd'(i_cmd) == wnts_pkg::CMD_APPEND) &&
                      (r_cnt != wnts_pkg::CNT_W'(wnts_pkg::TABLE_DEPTH));

    // Name table
    wnts_ram #(
        .WIDTH (wnts_pkg::NAME_W),
        .DEPTH (wnts_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[wnts_pkg::IDX_W-1:0]),
        .i_wr_data (in_name),
        .i_rd_en   (rd_en),
        .i_rd_addr (n_cur[wnts_pkg::IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Shared compare unit
    wnts_match u_match (
        .i_mode  (r_cmd),
        .i_query (r_q),
        .i_entry (rd_data),
        .o_hit   (hit)
    );

    assign last_entry = (r_cmd == wnts_pkg::CMD_WILD) ? (r_cur <= r_dis)
                                                      : ((r_cur + 7'd1) >= r_cnt);

    // Sequencer: next state, scan control and result word loading
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_q          = r_q;
        n_cnt        = r_cnt;
        n_cur        = r_cur;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_fin_status = r_fin_status;
        n_fin_idx    = r_fin_idx;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        rd_en        = 1'b0;

        unique case (r_state)
            wnts_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd        = wnts_pkg::t_cmd'(i_cmd);
                    n_q          = in_name;
                    n_pend_valid = 1'b0;
                    n_fin_idx    = '0;
                    n_fin_status = wnts_pkg::ST_NO_MATCH;
                    n_state      = wnts_pkg::S_EMIT;
                    unique case (wnts_pkg::t_cmd'(i_cmd))
                        wnts_pkg::CMD_APPEND: begin
                            if (wr_en) begin
                                n_fin_status = wnts_pkg::ST_APPENDED;
                                n_fin_idx    = r_cnt[wnts_pkg::IDX_W-1:0];
                                n_cnt        = r_cnt + 7'd1;
                            end else begin
                                n_fin_status = wnts_pkg::ST_FULL;
                            end
                        end
                        wnts_pkg::CMD_CLEAR: begin
                            n_fin_status = wnts_pkg::ST_CLEARED;
                            n_cnt        = '0;
                        end
                        wnts_pkg::CMD_WILD: begin
                            if (!in_empty && (r_cnt > r_dis)) begin
                                n_cur   = r_cnt - 7'd1;
                                rd_en   = 1'b1;
                                n_state = wnts_pkg::S_SCAN;
                            end
                        end
                        wnts_pkg::CMD_EXACT: begin
                            if (r_dis < r_cnt) begin
                                n_cur   = r_dis;
                                rd_en   = 1'b1;
                                n_state = wnts_pkg::S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            wnts_pkg::S_SCAN: begin
                if (r_cmd == wnts_pkg::CMD_EXACT) begin
                    // Stop at the first hit or at the top of the range
                    if (hit) begin
                        n_fin_status = wnts_pkg::ST_MATCH;
                        n_fin_idx    = r_cur[wnts_pkg::IDX_W-1:0];
                        n_state      = wnts_pkg::S_EMIT;
                    end else if (last_entry) begin
                        n_state = wnts_pkg::S_EMIT;
                    end else begin
                        n_cur = r_cur + 7'd1;
                        rd_en = 1'b1;
                    end
                end else if (!(hit && r_pend_valid && !out_free)) begin
                    // Release the held hit when a newer one replaces it
                    if (hit && r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_status = wnts_pkg::ST_MATCH;
                        n_out_idx    = r_pend_idx;
                        n_out_last   = 1'b0;
                    end
                    if (hit) begin
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_cur[wnts_pkg::IDX_W-1:0];
                    end
                    if (last_entry) begin
                        if (n_pend_valid) begin
                            n_fin_status = wnts_pkg::ST_MATCH;
                            n_fin_idx    = n_pend_idx;
                        end
                        n_state = wnts_pkg::S_EMIT;
                    end else begin
                        n_cur = r_cur - 7'd1;
                        rd_en = 1'b1;
                    end
                end
            end

            wnts_pkg::S_EMIT: begin
                // Send the closing word once the output register frees up
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_fin_status;
                    n_out_idx    = r_fin_idx;
                    n_out_last   = 1'b1;
                    n_state      = wnts_pkg::S_IDLE;
                end
            end

            default: n_state = wnts_pkg::S_IDLE;
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wnts_pkg::S_IDLE;
            r_cnt       <= '0;
            r_dis       <= '0;
            r_out_valid <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_wr_en) begin
                r_dis <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_q          <= n_q;
        r_cur        <= n_cur;
        r_pend_idx   <= n_pend_idx;
        r_fin_status <= n_fin_status;
        r_fin_idx    <= n_fin_idx;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_last   <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = r_out_idx;
    assign o_last        = r_out_last;

endmodule
